// ===== hw/rtl/lpkm_pkg.sv =====
// Shared types, codes and constants of the linear probe key index map.
package lpkm_pkg;

	localparam int unsigned TABLE_SLOTS_DEF = 64;
	localparam int unsigned INDEX_BITS_DEF = 16;

	localparam int unsigned KEY_W = 64;
	localparam int unsigned ENTRY_W = 16;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned HASH_W = 64;
	localparam int unsigned MIX_SHIFT = 33;
	localparam logic [HASH_W-1:0] MIX_MULT = 64'hff51afd7ed558ccd;

	localparam logic KIND_LOOKUP = 1'b0;
	localparam logic KIND_INSERT = 1'b1;

	localparam logic [STATUS_W-1:0] ST_HIT = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NEW = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL_OR_NULL = 3'd4;

	typedef struct packed {
		logic kind;
		logic [KEY_W-1:0] key;
		logic [ENTRY_W-1:0] entry_index;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ENTRY_W-1:0] found_index;
	} rsp_t;

	// write strobes into the slot memories
	typedef struct packed {
		logic we_used;
		logic we_data;
		logic used_val;
	} mem_wr_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PROBE
	} ctrl_state_t;

	typedef enum logic [2:0] {
		M_IDLE,
		M_MUL0,
		M_MUL1,
		M_MUL2,
		M_FOLD,
		M_MOD,
		M_SUB,
		M_DONE
	} mix_state_t;

endpackage

// ===== hw/rtl/lpkm_mixer.sv =====
// Key mixer: xor-shift, 64-bit multiply over three 32x32 products, home slot reduction.
module lpkm_mixer import lpkm_pkg::*; #(
	parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [KEY_W-1:0] key,
	output logic done,
	output logic [$clog2(TABLE_SLOTS)-1:0] slot
);

	localparam int unsigned SW = $clog2(TABLE_SLOTS);
	localparam bit POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
	localparam int unsigned DIG_W = 16;
	localparam logic [1:0] LAST_DIG = 2'(HASH_W / DIG_W - 1);
	localparam int unsigned RK = 32 + SW;
	localparam logic [63:0] RECIP = ((64'd1 << RK) / 64'(TABLE_SLOTS)) + 64'd1;
	localparam logic [31:0] RECIP_LO = RECIP[31:0];
	localparam logic [31:0] MOD_LO = 32'(TABLE_SLOTS);
	localparam logic [31:0] MULT_LO = MIX_MULT[31:0];
	localparam logic [31:0] MULT_HI = MIX_MULT[63:32];

	mix_state_t state_q, state_d;
	logic [HASH_W-1:0] x_q;
	logic [31:0] lo_q;
	logic [31:0] hi_q;
	logic [HASH_W-1:0] h_q;
	logic [SW-1:0] r_q;
	logic [DIG_W-1:0] q_q;
	logic [1:0] dig_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [HASH_W-1:0] folded;
	logic [31:0] mod_v;
	logic [64:0] qsum;

	assign prod = 64'(mul_a) * 64'(mul_b);
	assign folded = {hi_q, lo_q} ^ ({hi_q, lo_q} >> MIX_SHIFT);
	// running remainder on top of the next 16-bit hash digit
	assign mod_v = {DIG_W'(r_q), h_q[HASH_W-1 -: DIG_W]};
	// reciprocal is 2^32 plus its low word, so add the shifted operand back in
	assign qsum = {1'b0, mod_v, 32'd0} + {1'b0, prod};

	always_comb begin
		state_d = state_q;
		case (state_q)
			M_IDLE: if (start) state_d = M_MUL0;
			M_MUL0: state_d = M_MUL1;
			M_MUL1: state_d = M_MUL2;
			M_MUL2: state_d = M_FOLD;
			M_FOLD: state_d = POW2 ? M_DONE : M_MOD;
			M_MOD: state_d = M_SUB;
			M_SUB: state_d = (dig_q == LAST_DIG) ? M_DONE : M_MOD;
			M_DONE: state_d = M_IDLE;
			default: state_d = M_IDLE;
		endcase
	end

	always_comb begin
		done = 1'b0;
		mul_a = x_q[31:0];
		mul_b = MULT_LO;
		case (state_q)
			M_MUL1: mul_a = x_q[63:32];
			M_MUL2: mul_b = MULT_HI;
			M_MOD: begin
				mul_a = mod_v;
				mul_b = RECIP_LO;
			end
			M_SUB: begin
				mul_a = 32'(q_q);
				mul_b = MOD_LO;
			end
			M_DONE: done = 1'b1;
			default: ;
		endcase
	end

	assign slot = POW2 ? h_q[SW-1:0] : r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			dig_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == M_FOLD) dig_q <= '0;
			else if (state_q == M_SUB) dig_q <= dig_q + 2'd1;
		end
	end

	// only cross terms that land in the low 64 bits of the product are kept
	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: x_q <= key ^ (key >> MIX_SHIFT);
			M_MUL0: begin
				lo_q <= prod[31:0];
				hi_q <= prod[63:32];
			end
			M_MUL1: hi_q <= hi_q + prod[31:0];
			M_MUL2: hi_q <= hi_q + prod[31:0];
			M_FOLD: begin
				h_q <= folded;
				r_q <= '0;
			end
			M_MOD: q_q <= DIG_W'(qsum >> RK);
			M_SUB: begin
				// subtract quotient times slot count, advance to the next digit
				h_q <= {h_q[HASH_W-DIG_W-1:0], {DIG_W{1'b0}}};
				r_q <= SW'(mod_v - prod[31:0]);
			end
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/lpkm_slot_mem.sv =====
// Slot storage: used-bit memory and key/entry memory, one write and one registered read port.
module lpkm_slot_mem import lpkm_pkg::*; #(
	parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF,
	parameter int unsigned EW = ENTRY_W
) (
	input  logic clk,
	input  logic [$clog2(TABLE_SLOTS)-1:0] rd_addr,
	input  logic [$clog2(TABLE_SLOTS)-1:0] wr_addr,
	input  mem_wr_t wr,
	input  logic [KEY_W-1:0] wr_key,
	input  logic [EW-1:0] wr_entry,
	output logic rd_used,
	output logic [KEY_W-1:0] rd_key,
	output logic [EW-1:0] rd_entry
);

	logic used_mem [TABLE_SLOTS];
	logic [KEY_W+EW-1:0] data_mem [TABLE_SLOTS];

	logic rd_used_q;
	logic [KEY_W+EW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.we_used) used_mem[wr_addr] <= wr.used_val;
		if (wr.we_data) data_mem[wr_addr] <= {wr_key, wr_entry};
	end

	always_ff @(posedge clk) begin
		rd_used_q <= used_mem[rd_addr];
		rd_data_q <= data_mem[rd_addr];
	end

	assign rd_used = rd_used_q;
	assign rd_key = rd_data_q[KEY_W+EW-1:EW];
	assign rd_entry = rd_data_q[EW-1:0];

endmodule

// ===== hw/rtl/linear_probe_key_index_map.sv =====
// Linear probe key index map: a 64-bit key to entry index hash map with a wrapping probe walk.
//
// After reset the block sweeps the used bits, one slot a cycle, with busy high. A command is
// taken at a clock edge with start high and busy low. A zero key is answered in the next cycle
// and leaves busy low. Any other key runs the mixer (a 64-bit product built from three 32x32
// partial products on one multiplier, a fold, plus a remainder step per 16-bit hash digit on
// the same multiplier, a reciprocal multiply then a subtract, when TABLE_SLOTS is not a power
// of two), then walks the slots in turn: the home slot read is issued in the mixer's last
// cycle and the slot memory streams one read per cycle while the previous slot is compared.
// The result is registered, and busy drops in the same cycle that done rises; no new command
// is taken before then. Each result word is on result for exactly one cycle with done high;
// the receiver has to take it then, it cannot hold the block off.
module linear_probe_key_index_map import lpkm_pkg::*; #(
	parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF,
	parameter int unsigned INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output rsp_t result
);

	localparam int unsigned SW = $clog2(TABLE_SLOTS);
	localparam int unsigned EW = (INDEX_BITS < ENTRY_W) ? INDEX_BITS : ENTRY_W;
	localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_SLOTS - 1);

	ctrl_state_t state_q, state_d;
	req_t req_q;
	logic [SW-1:0] ev_q;
	logic [SW-1:0] addr_q;
	logic [SW-1:0] cnt_q;
	logic [SW-1:0] clr_q;
	logic done_q;
	rsp_t result_q;

	logic accept;
	logic null_key;
	logic mix_start;
	logic mix_done;
	logic [SW-1:0] mix_slot;
	logic [SW-1:0] rd_addr;
	logic [SW-1:0] wr_addr;
	mem_wr_t mem_wr;
	logic rd_used;
	logic [KEY_W-1:0] rd_key;
	logic [EW-1:0] rd_entry;
	logic slot_empty;
	logic slot_hit;
	logic probe_end;
	logic is_insert;
	rsp_t probe_rsp;

	function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + SW'(1);
	endfunction

	lpkm_mixer #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_mixer (
		.clk(clk),
		.arst_n(arst_n),
		.start(mix_start),
		.key(request.key),
		.done(mix_done),
		.slot(mix_slot)
	);

	lpkm_slot_mem #(
		.TABLE_SLOTS(TABLE_SLOTS),
		.EW(EW)
	) u_slot_mem (
		.clk(clk),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.wr(mem_wr),
		.wr_key(req_q.key),
		.wr_entry(req_q.entry_index[EW-1:0]),
		.rd_used(rd_used),
		.rd_key(rd_key),
		.rd_entry(rd_entry)
	);

	assign accept = start && !busy;
	assign null_key = request.key == '0;
	assign is_insert = req_q.kind == KIND_INSERT;

	// read data belongs to slot ev_q
	assign slot_empty = !rd_used;
	assign slot_hit = rd_used && (rd_key == req_q.key);
	assign probe_end = slot_empty || slot_hit || (cnt_q == LAST_SLOT);

	always_comb begin
		probe_rsp.found_index = '0;
		if (slot_empty) begin
			probe_rsp.status = is_insert ? ST_NEW : ST_MISS;
		end else if (slot_hit) begin
			probe_rsp.status = is_insert ? ST_REPLACED : ST_HIT;
			probe_rsp.found_index = ENTRY_W'(rd_entry);
		end else begin
			probe_rsp.status = is_insert ? ST_FULL_OR_NULL : ST_MISS;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == LAST_SLOT) state_d = S_IDLE;
			S_IDLE: if (accept && !null_key) state_d = S_HASH;
			S_HASH: if (mix_done) state_d = S_PROBE;
			S_PROBE: if (probe_end) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b1;
		mix_start = 1'b0;
		rd_addr = addr_q;
		wr_addr = ev_q;
		mem_wr = '0;
		case (state_q)
			S_CLEAR: begin
				wr_addr = clr_q;
				mem_wr.we_used = 1'b1;
			end
			S_IDLE: begin
				busy = 1'b0;
				mix_start = start && !null_key;
			end
			S_HASH: rd_addr = mix_slot;
			S_PROBE: begin
				if (is_insert && (slot_empty || slot_hit)) begin
					mem_wr.we_data = 1'b1;
					mem_wr.we_used = slot_empty;
					mem_wr.used_val = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: clr_q <= clr_q + SW'(1);
				S_IDLE: done_q <= accept && null_key;
				S_HASH: cnt_q <= '0;
				S_PROBE: begin
					done_q <= probe_end;
					cnt_q <= cnt_q + SW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) req_q <= request;
				result_q.status <= ST_FULL_OR_NULL;
				result_q.found_index <= '0;
			end
			S_HASH: begin
				ev_q <= mix_slot;
				addr_q <= next_slot(mix_slot);
			end
			S_PROBE: begin
				// advance the walk; the read of addr_q is already in flight
				ev_q <= addr_q;
				addr_q <= next_slot(addr_q);
				result_q <= probe_rsp;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign result = result_q;

	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_PROBE) || $past(accept))
		else $error("result word without a command behind it");

	a_null_key_answer: assert property (@(posedge clk) disable iff (!arst_n)
		accept && null_key |=> done && result.status == ST_FULL_OR_NULL)
		else $error("zero key not answered in the next cycle");

	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !(result.status == ST_HIT || result.status == ST_REPLACED)
			|-> result.found_index == '0)
		else $error("found_index set without a hit or replace");

	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_wr.we_used || mem_wr.we_data) |-> (state_q == S_CLEAR || state_q == S_PROBE))
		else $error("slot memory written outside clear or probe");

	a_probe_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PROBE && probe_end |=> done && !busy)
		else $error("probe end did not deliver a result and release busy");

endmodule

// ===== test/tb_linear_probe_key_index_map.sv =====
// Self-checking testbench for the linear probe key index map: shadow table, driver, monitor.
module tb_linear_probe_key_index_map import lpkm_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SLOTS = TABLE_SLOTS_DEF;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned TAIL_CYCLES = 100;
	localparam int unsigned WORDS_PER_PHASE = 510;

	// Shadow copy of the slot table plus the answers still owed by the block.
	class map_shadow;
		bit slot_used [SLOTS];
		logic [KEY_W-1:0] slot_key [SLOTS];
		logic [ENTRY_W-1:0] slot_entry [SLOTS];
		rsp_t answers_due [$];
		int unsigned errors;

		function new();
			foreach (slot_used[i]) slot_used[i] = 1'b0;
			errors = 0;
		endfunction

		static function int unsigned home_slot(logic [KEY_W-1:0] key);
			logic [HASH_W-1:0] h;
			h = key ^ (key >> MIX_SHIFT);
			h = h * MIX_MULT;
			h = h ^ (h >> MIX_SHIFT);
			return int'(h % SLOTS);
		endfunction

		// Walk the shadow table the way the block does and queue its answer.
		function void note_command(req_t cmd);
			rsp_t ans;
			int unsigned slot;
			logic [ENTRY_W-1:0] idx;
			ans.status = ST_FULL_OR_NULL;
			ans.found_index = '0;
			idx = cmd.entry_index;
			if (INDEX_BITS_DEF < ENTRY_W)
				idx = idx & ((ENTRY_W'(1) << INDEX_BITS_DEF) - 1'b1);
			if (cmd.key != '0) begin
				slot = home_slot(cmd.key);
				ans.status = (cmd.kind == KIND_INSERT) ? ST_FULL_OR_NULL : ST_MISS;
				for (int n = 0; n < SLOTS; n++) begin
					if (!slot_used[slot]) begin
						if (cmd.kind == KIND_INSERT) begin
							slot_used[slot] = 1'b1;
							slot_key[slot] = cmd.key;
							slot_entry[slot] = idx;
							ans.status = ST_NEW;
						end else begin
							ans.status = ST_MISS;
						end
						break;
					end
					if (slot_key[slot] == cmd.key) begin
						ans.found_index = slot_entry[slot];
						if (cmd.kind == KIND_INSERT) begin
							slot_entry[slot] = idx;
							ans.status = ST_REPLACED;
						end else begin
							ans.status = ST_HIT;
						end
						break;
					end
					slot = (slot + 1) % SLOTS;
				end
			end
			answers_due.push_back(ans);
		endfunction

		function void check_answer(rsp_t got);
			rsp_t want;
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected result word: expected none, got status %0d found_index %0h",
					$time, got.status, got.found_index);
				errors++;
				return;
			end
			want = answers_due.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status mismatch: expected %0d, got %0d",
					$time, want.status, got.status);
				errors++;
			end
			if (got.found_index !== want.found_index) begin
				$display("%0t: found_index mismatch: expected %0h, got %0h",
					$time, want.found_index, got.found_index);
				errors++;
			end
		endfunction

		function int unsigned due_count();
			return answers_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t request;
	rsp_t result;

	map_shadow shadow = new();
	logic [KEY_W-1:0] known_keys [$];
	int unsigned gap_pct;
	int unsigned quiet_cycles;

	linear_probe_key_index_map i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Take accepted words from both sides and watch for a stuck block.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else begin
			if (start && !busy)
				shadow.note_command(request);
			if (done)
				shadow.check_answer(result);
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no word accepted for %0d cycles", $time, quiet_cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic issue(logic kind, logic [KEY_W-1:0] key, logic [ENTRY_W-1:0] idx);
		req_t cmd;
		req_t junk;
		cmd.kind = kind;
		cmd.key = key;
		cmd.entry_index = idx;
		while ($urandom_range(99) < gap_pct) begin
			junk.kind = 1'($urandom_range(1));
			junk.key = {$urandom, $urandom};
			junk.entry_index = 16'($urandom);
			start <= 1'b0;
			request <= junk;
			@(posedge clk);
		end
		start <= 1'b1;
		request <= cmd;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Hold off new commands until every answer is in.
	task automatic wait_all_answered();
		start <= 1'b0;
		do @(posedge clk); while (shadow.due_count() != 0);
	endtask

	function automatic logic [KEY_W-1:0] key_homed_at(int unsigned target,
			logic [KEY_W-1:0] from);
		logic [KEY_W-1:0] k;
		k = from;
		while (map_shadow::home_slot(k) != target) k++;
		return k;
	endfunction

	function automatic logic [KEY_W-1:0] fresh_key();
		logic [KEY_W-1:0] k;
		if ($urandom_range(9) == 0)
			return 64'd1 << $urandom_range(KEY_W - 1);
		k = {$urandom, $urandom};
		if (k == '0)
			k = 64'd1;
		return k;
	endfunction

	task automatic random_command();
		int unsigned roll;
		logic [KEY_W-1:0] k;
		logic [ENTRY_W-1:0] idx;
		roll = $urandom_range(99);
		idx = 16'($urandom);
		if (roll < 5) begin
			issue(1'($urandom_range(1)), '0, idx);
		end else if (roll < 11 || known_keys.size() == 0) begin
			k = fresh_key();
			known_keys.push_back(k);
			issue(KIND_INSERT, k, idx);
		end else if (roll < 41) begin
			issue(KIND_INSERT, known_keys[$urandom_range(known_keys.size() - 1)], idx);
		end else if (roll < 76) begin
			issue(KIND_LOOKUP, known_keys[$urandom_range(known_keys.size() - 1)], idx);
		end else begin
			issue(KIND_LOOKUP, fresh_key(), idx);
		end
	endtask

	initial begin
		logic [KEY_W-1:0] c1, c2, w1, w2, w3;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		gap_pct = 9;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// null keys, empty table, replace and hit on extreme keys and indexes
		issue(KIND_LOOKUP, '0, 16'hffff);
		issue(KIND_INSERT, '0, 16'hffff);
		issue(KIND_LOOKUP, 64'd1, '0);
		issue(KIND_INSERT, 64'd1, '0);
		issue(KIND_INSERT, 64'd1, 16'hffff);
		issue(KIND_LOOKUP, 64'd1, '0);
		issue(KIND_INSERT, '1, 16'h5a5a);
		issue(KIND_LOOKUP, '1, '0);
		issue(KIND_INSERT, 64'h8000_0000_0000_0000, 16'h8000);
		issue(KIND_INSERT, 64'h8000_0000_0000_0000, 16'h0001);

		// keys that share a home slot: probe past an occupied slot
		c1 = key_homed_at(map_shadow::home_slot(64'd1), 64'd2);
		c2 = key_homed_at(map_shadow::home_slot(64'd1), c1 + 1);
		issue(KIND_INSERT, c1, 16'h00ff);
		issue(KIND_LOOKUP, c1, '0);
		issue(KIND_LOOKUP, c2, '0);
		issue(KIND_INSERT, c2, 16'h7fff);
		issue(KIND_INSERT, c2, '0);

		// home slot at the top of the table: the walk wraps to slot zero
		w1 = key_homed_at(SLOTS - 1, 64'd2);
		w2 = key_homed_at(SLOTS - 1, w1 + 1);
		w3 = key_homed_at(SLOTS - 1, w2 + 1);
		issue(KIND_INSERT, w1, 16'h1234);
		issue(KIND_INSERT, w2, 16'h4321);
		issue(KIND_INSERT, w3, 16'hbeef);
		issue(KIND_LOOKUP, w3, '0);

		known_keys = '{64'd1, '1, 64'h8000_0000_0000_0000, c1, c2, w1, w2, w3};
		wait_all_answered();

		// the table fills over the run; later phases see a full table
		gap_pct = 9;
		repeat (WORDS_PER_PHASE) random_command();
		wait_all_answered();
		gap_pct = 57;
		repeat (WORDS_PER_PHASE) random_command();
		wait_all_answered();
		gap_pct = 0;
		repeat (WORDS_PER_PHASE) random_command();
		wait_all_answered();

		// catch stray result words after the last answer
		repeat (TAIL_CYCLES) @(posedge clk);
		if (shadow.due_count() != 0) begin
			$display("%0t: expected %0d more result words, got none",
				$time, shadow.due_count());
			shadow.errors++;
		end
		if (shadow.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
